// ----- rtl/msps_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and functions of the multi-servo pulse sequencer.
package msps_pkg;

	localparam int MAX_CHANNELS     = 12;
	localparam int CH_W             = 4;
	localparam int SLOT_W           = $clog2(MAX_CHANNELS);
	localparam int US_W             = 16;
	localparam int TICK_W           = 19;
	localparam int CNT_W            = 20;
	localparam int FRAME_W          = 24;
	localparam int ANG_W            = 8;
	localparam int DATA_W           = 32;
	localparam int ADDR_W           = 5;
	localparam int REG_IDX_W        = ADDR_W - 2;

	localparam int MIN_PULSE_US     = 544;
	localparam int MAX_PULSE_US     = 2400;
	localparam int DEFAULT_PULSE_US = 1500;
	localparam int TICKS_PER_US     = 5;
	localparam int ANGLE_MAX        = 180;
	localparam int GAP_MIN_TICKS    = 4;

	localparam int LIMIT_MIN_RST    = 544;
	localparam int LIMIT_MAX_RST    = 2400;
	localparam int REFRESH_RST      = 20000;

	localparam int SPAN_US          = MAX_PULSE_US - MIN_PULSE_US;
	localparam int SPAN_W           = $clog2(SPAN_US);
	localparam int ANG_IDX_W        = $clog2(ANGLE_MAX + 1);
	localparam int ANG_SHIFT        = 26;
	localparam longint ANG_MUL      =
		((longint'(ANGLE_MAX) << ANG_SHIFT) + longint'(SPAN_US) - 1) / longint'(SPAN_US);
	localparam int ANG_MUL_W        = $clog2(ANG_MUL + 1);
	localparam int ANG_PROD_W       = SPAN_W + ANG_MUL_W;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WPOS  = 2'd1;
	localparam logic [1:0] CMD_WUS   = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVE_MASK   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_MIN_US  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT_MAX_US  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REFRESH_US    = 3'd4;

	typedef struct packed {
		logic [CH_W-1:0]         channel_count;
		logic [MAX_CHANNELS-1:0] active_mask;
		logic [US_W-1:0]         limit_min_us;
		logic [US_W-1:0]         limit_max_us;
		logic [US_W-1:0]         refresh_us;
	} cfg_t;

	typedef struct packed {
		logic [MAX_CHANNELS-1:0] pulse_mask;
		logic                    status;
		logic                    rd_en;
		logic [US_W-1:0]         rd_us;
	} item_t;

	typedef logic [US_W-1:0] ang_tbl_t [ANGLE_MAX+1];

	function automatic ang_tbl_t build_ang_tbl();
		ang_tbl_t t;
		for (int i = 0; i <= ANGLE_MAX; i++) begin
			t[i] = US_W'(MIN_PULSE_US + (i * SPAN_US) / ANGLE_MAX);
		end
		return t;
	endfunction

	localparam ang_tbl_t ANG_TBL = build_ang_tbl();

	function automatic logic [TICK_W-1:0] ticks_from_us(input logic [US_W-1:0] us);
		return TICK_W'(us) * TICK_W'(TICKS_PER_US);
	endfunction

endpackage

// ----- rtl/msps_engine.sv -----
`timescale 1ns / 1ps
// Width memory, frame scheduler and request execution of the servo pulse sequencer.
module msps_engine import msps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            fire,
	input  logic [1:0]      cmd,
	input  logic [CH_W-1:0] channel,
	input  logic [US_W-1:0] value,
	output logic            hold,
	output item_t           s1
);

	logic [US_W-1:0]         width_mem_q [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] width_vld_q;

	logic [CNT_W-1:0]        countdown_q, countdown_d;
	logic [SLOT_W-1:0]       slot_q, slot_d;
	logic                    in_gap_q, in_gap_d;
	logic [FRAME_W-1:0]      frame_q, frame_d;
	logic [US_W-1:0]         cur_us_q, cur_us_d;

	logic [US_W-1:0]         nxt_us_q;
	logic                    nxt_vld_q;
	logic [SLOT_W-1:0]       nxt_addr_q;
	logic                    nxt_rd_q;

	logic [US_W-1:0]         rd_us_q;
	logic                    rd_vld_q;
	logic [MAX_CHANNELS-1:0] s1_mask_q;
	logic                    s1_status_q;
	logic                    s1_rd_q;

	logic                    ch_ok;
	logic [SLOT_W-1:0]       ch_idx;
	logic                    is_tick, is_wr, is_rd;
	logic [US_W-1:0]         wr_us;
	logic                    wr_clamp;

	logic [CH_W-1:0]         cnt_lim;
	logic [MAX_CHANNELS-1:0] elig;
	logic [SLOT_W:0]         nxt_cur, nxt_new;
	logic                    nxt_found;
	logic [SLOT_W-1:0]       nxt_slot, nxt_slot_n;
	logic [US_W-1:0]         nxt_us_eff;
	logic                    nxt_ok;
	logic                    fwd_n;

	logic [TICK_W-1:0]       cur_ticks;
	logic [FRAME_W:0]        frame_sum;
	logic [FRAME_W-1:0]      frame_end;
	logic [FRAME_W-1:0]      frame_cap;
	logic [CNT_W-1:0]        gap_cnt;
	logic [MAX_CHANNELS-1:0] mask_d;

	function automatic logic [SLOT_W:0] next_after(
		input logic [MAX_CHANNELS-1:0] el,
		input logic                    gap,
		input logic [SLOT_W-1:0]       slot
	);
		logic              found;
		logic [SLOT_W-1:0] idx;
		found = 1'b0;
		idx   = '0;
		for (int c = MAX_CHANNELS - 1; c >= 0; c--) begin
			if (el[c] && (gap || SLOT_W'(c) > slot)) begin
				found = 1'b1;
				idx   = SLOT_W'(c);
			end
		end
		return {found, idx};
	endfunction

	assign ch_ok   = channel < CH_W'(MAX_CHANNELS);
	assign ch_idx  = channel[SLOT_W-1:0];
	assign is_tick = fire && (cmd == CMD_TICK);
	assign is_wr   = fire && (cmd == CMD_WPOS || cmd == CMD_WUS) && ch_ok;
	assign is_rd   = fire && (cmd == CMD_READ) && ch_ok;

	always_comb begin
		wr_us    = value;
		wr_clamp = 1'b0;
		if (cmd == CMD_WPOS && value <= US_W'(ANGLE_MAX)) begin
			wr_us = ANG_TBL[value[ANG_IDX_W-1:0]];
		end else if (value < cfg.limit_min_us) begin
			wr_us    = cfg.limit_min_us;
			wr_clamp = 1'b1;
		end else if (value > cfg.limit_max_us) begin
			wr_us    = cfg.limit_max_us;
			wr_clamp = 1'b1;
		end
	end

	assign cnt_lim = (cfg.channel_count > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS)
	                                                            : cfg.channel_count;

	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			elig[c] = cfg.active_mask[c] && (CH_W'(c) < cnt_lim);
		end
	end

	assign nxt_cur    = next_after(elig, in_gap_q, slot_q);
	assign nxt_found  = nxt_cur[SLOT_W];
	assign nxt_slot   = nxt_cur[SLOT_W-1:0];
	assign nxt_us_eff = nxt_vld_q ? nxt_us_q : US_W'(DEFAULT_PULSE_US);
	assign nxt_ok     = nxt_rd_q && (nxt_addr_q == nxt_slot);
	assign hold       = (countdown_q <= CNT_W'(1)) && nxt_found && !nxt_ok;

	assign cur_ticks = ticks_from_us(cur_us_q);
	assign frame_sum = {1'b0, frame_q} + (FRAME_W + 1)'(cur_ticks);
	assign frame_end = in_gap_q ? '0 : (frame_sum[FRAME_W] ? '1 : frame_sum[FRAME_W-1:0]);
	assign frame_cap = FRAME_W'(ticks_from_us(cfg.refresh_us));
	assign gap_cnt   = (frame_cap > frame_end) ? CNT_W'(frame_cap - frame_end)
	                                           : CNT_W'(GAP_MIN_TICKS);

	always_comb begin
		countdown_d = countdown_q;
		slot_d      = slot_q;
		in_gap_d    = in_gap_q;
		frame_d     = frame_q;
		cur_us_d    = cur_us_q;
		if (is_tick) begin
			if (countdown_q <= CNT_W'(1)) begin
				frame_d = frame_end;
				if (nxt_found) begin
					slot_d      = nxt_slot;
					in_gap_d    = 1'b0;
					countdown_d = CNT_W'(ticks_from_us(nxt_us_eff));
					cur_us_d    = nxt_us_eff;
				end else begin
					slot_d      = '0;
					in_gap_d    = 1'b1;
					countdown_d = gap_cnt;
				end
			end else begin
				countdown_d = countdown_q - CNT_W'(1);
			end
		end
		if (is_wr && ch_idx == slot_q) begin
			cur_us_d = wr_us;
		end
	end

	assign nxt_new    = next_after(elig, in_gap_d, slot_d);
	assign nxt_slot_n = nxt_new[SLOT_W-1:0];
	assign fwd_n      = is_wr && (ch_idx == nxt_slot_n);
	assign mask_d     = in_gap_d ? '0 : (MAX_CHANNELS'(1) << slot_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= CNT_W'(GAP_MIN_TICKS);
			slot_q      <= '0;
			in_gap_q    <= 1'b1;
			frame_q     <= '0;
			cur_us_q    <= US_W'(DEFAULT_PULSE_US);
			width_vld_q <= '0;
			nxt_rd_q    <= 1'b0;
			nxt_addr_q  <= '0;
			nxt_vld_q   <= 1'b0;
			rd_vld_q    <= 1'b0;
		end else begin
			countdown_q <= countdown_d;
			slot_q      <= slot_d;
			in_gap_q    <= in_gap_d;
			frame_q     <= frame_d;
			cur_us_q    <= cur_us_d;
			if (is_wr) begin
				width_vld_q[ch_idx] <= 1'b1;
			end
			nxt_rd_q   <= 1'b1;
			nxt_addr_q <= nxt_slot_n;
			nxt_vld_q  <= fwd_n ? 1'b1 : width_vld_q[nxt_slot_n];
			if (fire) begin
				rd_vld_q <= width_vld_q[ch_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_wr) begin
			width_mem_q[ch_idx] <= wr_us;
		end
		nxt_us_q <= fwd_n ? wr_us : width_mem_q[nxt_slot_n];
		if (fire) begin
			rd_us_q     <= width_mem_q[ch_idx];
			s1_mask_q   <= mask_d;
			s1_status_q <= is_wr && wr_clamp;
			s1_rd_q     <= is_rd;
		end
	end

	assign s1.pulse_mask = s1_mask_q;
	assign s1.status     = s1_status_q;
	assign s1.rd_en      = s1_rd_q;
	assign s1.rd_us      = s1_rd_q ? (rd_vld_q ? rd_us_q : US_W'(DEFAULT_PULSE_US)) : '0;

endmodule

// ----- rtl/multi_servo_pulse_sequencer_top.sv -----
`timescale 1ns / 1ps
// Top level of the multi-servo pulse sequencer: register port, request pipeline, readout.
// One request enters per clock unless stalled: tick, position write, microsecond write
// or read. Each request is executed in the cycle it is accepted and its result passes
// through a two-stage pipeline ending in the response register, so the sustained rate
// is one request per cycle while nothing stalls. The width of the next channel in the
// frame is prefetched from the second read port of the 12-entry width memory; only
// right after a register write, when the very next tick ends a phase, is the request
// port held while that prefetch refreshes. A stalled response holds the pipeline.
module multi_servo_pulse_sequencer_top import msps_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              cmd,
	input  logic [CH_W-1:0]         channel,
	input  logic [US_W-1:0]         value,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [MAX_CHANNELS-1:0] pulse_mask,
	output logic                    status,
	output logic [US_W-1:0]         read_us,
	output logic [ANG_W-1:0]        read_angle
);

	cfg_t                    cfg_q;
	logic                    cfg_wr;
	logic [REG_IDX_W-1:0]    reg_idx;

	logic                    hold;
	item_t                   eng_s1;
	logic                    fire;
	logic                    s1_vld_q;
	logic                    s2_free;

	logic                    rsp_vld_q;
	logic [MAX_CHANNELS-1:0] mask_q;
	logic                    status_q;
	logic [US_W-1:0]         read_us_q;
	logic [ANG_W-1:0]        angle_q;

	logic [US_W-1:0]         ang_d;
	logic [ANG_PROD_W-1:0]   ang_prod;
	logic [ANG_W-1:0]        ang_val;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= '0;
			cfg_q.active_mask   <= '0;
			cfg_q.limit_min_us  <= US_W'(LIMIT_MIN_RST);
			cfg_q.limit_max_us  <= US_W'(LIMIT_MAX_RST);
			cfg_q.refresh_us    <= US_W'(REFRESH_RST);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[CH_W-1:0];
				REG_ACTIVE_MASK:   cfg_q.active_mask   <= pwdata[MAX_CHANNELS-1:0];
				REG_LIMIT_MIN_US:  cfg_q.limit_min_us  <= pwdata[US_W-1:0];
				REG_LIMIT_MAX_US:  cfg_q.limit_max_us  <= pwdata[US_W-1:0];
				REG_REFRESH_US:    cfg_q.refresh_us    <= pwdata[US_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CHANNEL_COUNT: prdata = DATA_W'(cfg_q.channel_count);
			REG_ACTIVE_MASK:   prdata = DATA_W'(cfg_q.active_mask);
			REG_LIMIT_MIN_US:  prdata = DATA_W'(cfg_q.limit_min_us);
			REG_LIMIT_MAX_US:  prdata = DATA_W'(cfg_q.limit_max_us);
			REG_REFRESH_US:    prdata = DATA_W'(cfg_q.refresh_us);
			default:           prdata = '0;
		endcase
	end

	assign s2_free   = !rsp_vld_q || !rsp_stall;
	assign req_stall = hold || (s1_vld_q && !s2_free);
	assign fire      = req_valid && !req_stall;

	msps_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.fire    (fire),
		.cmd     (cmd),
		.channel (channel),
		.value   (value),
		.hold    (hold),
		.s1      (eng_s1)
	);

	assign ang_d    = eng_s1.rd_us - US_W'(MIN_PULSE_US);
	assign ang_prod = ANG_PROD_W'(ang_d[SPAN_W-1:0]) * ANG_PROD_W'(ANG_MUL);

	always_comb begin
		if (!eng_s1.rd_en || eng_s1.rd_us <= US_W'(MIN_PULSE_US)) begin
			ang_val = '0;
		end else if (ang_d >= US_W'(SPAN_US)) begin
			ang_val = ANG_W'(ANGLE_MAX);
		end else begin
			ang_val = ang_prod[ANG_SHIFT +: ANG_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= fire || (s1_vld_q && !s2_free);
			if (s2_free) begin
				rsp_vld_q <= s1_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld_q && s2_free) begin
			mask_q    <= eng_s1.pulse_mask;
			status_q  <= eng_s1.status;
			read_us_q <= eng_s1.rd_us;
			angle_q   <= ang_val;
		end
	end

	assign rsp_valid  = rsp_vld_q;
	assign pulse_mask = mask_q;
	assign status     = status_q;
	assign read_us    = read_us_q;
	assign read_angle = angle_q;

endmodule

// ----- rtl/msps_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the multi-servo pulse sequencer and its binding to the top level.
module msps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [11:0] pulse_mask,
	input logic        status,
	input logic [15:0] read_us,
	input logic [7:0]  read_angle
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(pulse_mask) && $stable(status)
			&& $stable(read_us) && $stable(read_angle))
		else $error("stalled response changed");

	a_one_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0(pulse_mask))
		else $error("more than one servo output driven");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> read_angle <= 8'd180)
		else $error("read angle above 180");

	a_angle_floor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_us <= 16'd544 |-> read_angle == 8'd0)
		else $error("nonzero angle for width at or below minimum");

	a_clamp_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> read_us == 16'd0 && read_angle == 8'd0)
		else $error("clamp status on a read response");

endmodule

bind multi_servo_pulse_sequencer_top msps_checker u_msps_checker (.*);

// ----- bench/multi_servo_pulse_sequencer_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the multi-servo pulse sequencer: directed and random requests against a predictor.
module multi_servo_pulse_sequencer_top_tb;
	import msps_pkg::*;

	typedef struct packed {
		logic [MAX_CHANNELS-1:0] pulse_mask;
		logic                    status;
		logic [US_W-1:0]         read_us;
		logic [ANG_W-1:0]        read_angle;
	} servo_rsp_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDR_W-1:0]       paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic [1:0]              cmd = CMD_TICK;
	logic [CH_W-1:0]         channel = '0;
	logic [US_W-1:0]         value = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic [MAX_CHANNELS-1:0] pulse_mask;
	logic                    status;
	logic [US_W-1:0]         read_us;
	logic [ANG_W-1:0]        read_angle;

	cfg_t               cfg;
	logic [TICK_W-1:0]  width_mem [MAX_CHANNELS];
	logic [CH_W-1:0]    slot_q;
	logic               gap_q;
	logic [CNT_W-1:0]   count_q;
	logic [FRAME_W-1:0] frame_q;

	servo_rsp_t pending_responses [$];
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         hold_cycles = 0;

	multi_servo_pulse_sequencer_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.channel    (channel),
		.value      (value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.pulse_mask (pulse_mask),
		.status     (status),
		.read_us    (read_us),
		.read_angle (read_angle)
	);

	always #5 clk = ~clk;

	function automatic int seq_length();
		return (cfg.channel_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(cfg.channel_count);
	endfunction

	function automatic void close_phase();
		int     first;
		int     c;
		longint total;
		longint frame_len;
		first = 0;
		if (gap_q) begin
			frame_q = '0;
		end else begin
			total = longint'(frame_q) + longint'(width_mem[slot_q]);
			frame_q = (total > longint'(24'hFFFFFF)) ? '1 : FRAME_W'(total);
			first = int'(slot_q) + 1;
		end
		for (c = first; c < seq_length(); c++) begin
			if (cfg.active_mask[c]) begin
				slot_q = CH_W'(c);
				gap_q = 1'b0;
				count_q = CNT_W'(width_mem[c]);
				return;
			end
		end
		frame_len = longint'(cfg.refresh_us) * TICKS_PER_US;
		gap_q = 1'b1;
		slot_q = '0;
		if (longint'(frame_q) < frame_len) begin
			total = frame_len - longint'(frame_q);
			count_q = (total > longint'(20'hFFFFF)) ? '1 : CNT_W'(total);
		end else begin
			count_q = CNT_W'(GAP_MIN_TICKS);
		end
	endfunction

	function automatic servo_rsp_t predict_servo(input logic [1:0] op,
			input logic [CH_W-1:0] ch, input logic [US_W-1:0] val);
		servo_rsp_t r;
		int         us;
		int         ticks;
		int         rus;
		int         d;
		int         ang;
		r = '0;
		case (op)
			CMD_TICK: begin
				if (count_q <= 1) begin
					count_q = '0;
					close_phase();
				end else begin
					count_q = count_q - 1'b1;
				end
			end
			CMD_WPOS, CMD_WUS: begin
				if (ch < MAX_CHANNELS) begin
					if (op == CMD_WPOS && val <= ANGLE_MAX) begin
						us = MIN_PULSE_US + (int'(val) * SPAN_US) / ANGLE_MAX;
					end else if (val < cfg.limit_min_us) begin
						us = int'(cfg.limit_min_us);
						r.status = 1'b1;
					end else if (val > cfg.limit_max_us) begin
						us = int'(cfg.limit_max_us);
						r.status = 1'b1;
					end else begin
						us = int'(val);
					end
					ticks = us * TICKS_PER_US;
					width_mem[ch] = (ticks > 'h7FFFF) ? '1 : TICK_W'(ticks);
				end
			end
			CMD_READ: begin
				if (ch < MAX_CHANNELS) begin
					rus = int'(width_mem[ch]) / TICKS_PER_US;
					if (rus > 65535)
						rus = 65535;
					d = rus - MIN_PULSE_US;
					ang = 0;
					if (d > 0) begin
						ang = (d * ANGLE_MAX) / SPAN_US;
						if (ang > ANGLE_MAX)
							ang = ANGLE_MAX;
					end
					r.read_us = US_W'(rus);
					r.read_angle = ANG_W'(ang);
				end
			end
		endcase
		r.pulse_mask = gap_q ? '0 : (MAX_CHANNELS'(1) << slot_q);
		return r;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [CH_W-1:0] ch,
			input logic [US_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= op;
		channel <= ch;
		value <= val;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_responses.push_back(predict_servo(op, ch, val));
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CHANNEL_COUNT: cfg.channel_count = data[CH_W-1:0];
			REG_ACTIVE_MASK:   cfg.active_mask = data[MAX_CHANNELS-1:0];
			REG_LIMIT_MIN_US:  cfg.limit_min_us = data[US_W-1:0];
			REG_LIMIT_MAX_US:  cfg.limit_max_us = data[US_W-1:0];
			REG_REFRESH_US:    cfg.refresh_us = data[US_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_sequence(input int count, input int mask, input int lo_us, input int hi_us,
			input int refresh);
		wait_drained();
		write_register(REG_CHANNEL_COUNT, DATA_W'(count));
		write_register(REG_ACTIVE_MASK, DATA_W'(mask));
		write_register(REG_LIMIT_MIN_US, DATA_W'(lo_us));
		write_register(REG_LIMIT_MAX_US, DATA_W'(hi_us));
		write_register(REG_REFRESH_US, DATA_W'(refresh));
	endtask

	task automatic load_widths();
		int c;
		for (c = 0; c < MAX_CHANNELS; c++)
			send_request(CMD_WUS, CH_W'(c), US_W'($urandom_range(cfg.limit_max_us)));
	endtask

	task automatic random_requests(input int n);
		int              i;
		int              pick;
		logic [CH_W-1:0] ch;
		logic [US_W-1:0] val;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			ch = CH_W'($urandom_range(15));
			val = US_W'($urandom);
			if (pick < 62) begin
				send_request(CMD_TICK, ch, val);
			end else if (pick < 74) begin
				if ($urandom_range(1))
					val = US_W'($urandom_range(int'(cfg.limit_max_us) + 3));
				send_request(CMD_WUS, ch, val);
			end else if (pick < 82) begin
				send_request(CMD_WPOS, ch, US_W'($urandom_range(65535, ANGLE_MAX + 1)));
			end else if (pick < 87) begin
				// keep long angle widths off channels in the running sequence
				if (ch < seq_length() && cfg.active_mask[ch])
					ch = CH_W'(MAX_CHANNELS + $urandom_range(3));
				send_request(CMD_WPOS, ch, US_W'($urandom_range(ANGLE_MAX)));
			end else begin
				send_request(CMD_READ, ch, val);
			end
		end
	endtask

	task automatic test_width_encoding();
		send_request(CMD_WPOS, 4'd0, 16'd0);
		send_request(CMD_READ, 4'd0, 16'd0);
		send_request(CMD_WPOS, 4'd1, 16'd180);
		send_request(CMD_READ, 4'd1, 16'hFFFF);
		send_request(CMD_WPOS, 4'd2, 16'd90);
		send_request(CMD_READ, 4'd2, 16'd0);
		send_request(CMD_WPOS, 4'd3, 16'd181);
		send_request(CMD_WUS, 4'd4, 16'd0);
		send_request(CMD_WUS, 4'd4, 16'hFFFF);
		send_request(CMD_WUS, 4'd5, 16'd544);
		send_request(CMD_WUS, 4'd5, 16'd2400);
		send_request(CMD_WUS, 4'd12, 16'd1000);
		send_request(CMD_WPOS, 4'd15, 16'd0);
		send_request(CMD_READ, 4'd15, 16'd0);
		send_request(CMD_READ, 4'd12, 16'd0);
		send_request(CMD_READ, 4'd6, 16'd0);
		send_request(CMD_READ, 4'd11, 16'd0);
		wait_drained();
		write_register(REG_LIMIT_MIN_US, DATA_W'(65535));
		write_register(REG_LIMIT_MAX_US, DATA_W'(65535));
		send_request(CMD_WUS, 4'd6, 16'hFFFF);
		send_request(CMD_READ, 4'd6, 16'd0);
		send_request(CMD_WUS, 4'd7, 16'd0);
		send_request(CMD_READ, 4'd7, 16'd0);
		wait_drained();
		write_register(REG_LIMIT_MIN_US, DATA_W'(100));
		write_register(REG_LIMIT_MAX_US, DATA_W'(50));
		send_request(CMD_WUS, 4'd8, 16'd70);
		send_request(CMD_WUS, 4'd8, 16'd60000);
		send_request(CMD_READ, 4'd8, 16'd0);
	endtask

	task automatic test_zero_width_frames();
		send_idle_pct = 0;
		stall_pct = 0;
		set_sequence(12, $urandom_range(4095) | 1, 0, 4, 0);
		load_widths();
		send_request(CMD_WUS, 4'd0, 16'd0);
		random_requests(190);
	endtask

	task automatic test_padded_frames();
		send_idle_pct = 46;
		stall_pct = 0;
		set_sequence(15, 4095, 1, 3, 40);
		load_widths();
		random_requests(190);
	endtask

	task automatic test_backpressure_fill();
		send_idle_pct = 0;
		stall_pct = 46;
		set_sequence(6, $urandom_range(4095), 2, 5, 5);
		load_widths();
		hold_cycles = 80;
		random_requests(190);
	endtask

	task automatic test_mixed_idle();
		send_idle_pct = 8;
		stall_pct = 8;
		set_sequence(9, $urandom_range(4095), 1, 4, 12);
		load_widths();
		random_requests(160);
	endtask

	task automatic test_sequence_extremes();
		int i;
		send_idle_pct = 0;
		stall_pct = 0;
		set_sequence(0, 0, 1, 4, 0);
		for (i = 0; i < 10; i++)
			send_request(CMD_TICK, CH_W'($urandom_range(15)), US_W'($urandom));
		wait_drained();
		write_register(REG_REFRESH_US, DATA_W'(65535));
		random_requests(30);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_responses
		servo_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: response with none pending", $time);
			end else begin
				want = pending_responses.pop_front();
				if (pulse_mask !== want.pulse_mask || status !== want.status ||
						read_us !== want.read_us || read_angle !== want.read_angle) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: expected mask %h status %0d us %0d angle %0d",
							$time, want.pulse_mask, want.status, want.read_us,
							want.read_angle);
						$display("%0t: got mask %h status %0d us %0d angle %0d",
							$time, pulse_mask, status, read_us, read_angle);
					end
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int c;
		cfg.channel_count = '0;
		cfg.active_mask = '0;
		cfg.limit_min_us = US_W'(LIMIT_MIN_RST);
		cfg.limit_max_us = US_W'(LIMIT_MAX_RST);
		cfg.refresh_us = US_W'(REFRESH_RST);
		for (c = 0; c < MAX_CHANNELS; c++)
			width_mem[c] = TICK_W'(DEFAULT_PULSE_US * TICKS_PER_US);
		slot_q = '0;
		gap_q = 1'b1;
		count_q = CNT_W'(GAP_MIN_TICKS);
		frame_q = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		test_width_encoding();
		test_zero_width_frames();
		test_padded_frames();
		test_backpressure_fill();
		test_mixed_idle();
		test_sequence_extremes();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_responses.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
